>>> rtl/lfu_page_replacement_defines.svh
// Assertion macros shared by the LFU page replacement checkers.
`ifndef LFU_PAGE_REPLACEMENT_DEFINES_SVH
`define LFU_PAGE_REPLACEMENT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define LFUPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never shows on a rising clock edge outside reset.
`define LFUPR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/lfupr_pkg.sv
// Package with word types and defaults of the LFU page replacement block.
package lfupr_pkg;

  localparam int unsigned FramesDef   = 256;
  localparam int unsigned PageBitsDef = 16;
  localparam int unsigned ProcsDef    = 4;
  localparam int unsigned UseW        = 32;
  localparam int unsigned OwnerW      = 2;
  localparam logic [UseW-1:0] UseMax  = '1;

  typedef struct packed {
    logic [1:0]  process_id;
    logic [15:0] virtual_page;
    logic [15:0] page_offset;
    logic        is_write;
  } lfupr_in_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  frame_index;
    logic [15:0] phys_offset;
    logic        evicted;
    logic [1:0]  evicted_process;
    logic [15:0] evicted_page;
    logic        swap_out;
    logic [31:0] fault_total;
    logic [31:0] swap_total;
  } lfupr_out_t;

endpackage

>>> rtl/lfupr_cell.sv
// One frame cell: holds a frame record and passes the search token onward.
module lfupr_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned FIDX_W    = 8,
  parameter int unsigned FP_W      = 9,
  parameter int unsigned PAGE_BITS = 16,
  parameter type tok_t = logic,
  parameter type upd_t = logic
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           q_proc_i,
  input  logic [PAGE_BITS-1:0] q_page_i,
  input  logic [FP_W-1:0]      free_ptr_i,
  input  upd_t                 upd_i,
  input  tok_t                 tok_i,
  output tok_t                 tok_o
);
  import lfupr_pkg::*;

  logic [OwnerW-1:0]    owner_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [UseW-1:0]      uses_q;
  logic                 dirty_q;
  logic                 own;
  tok_t                 tok_d, tok_q;

  // A filled frame that holds the queried page
  assign own = (FP_W'(IDX) < free_ptr_i) && (owner_q == q_proc_i) && (page_q == q_page_i);

  // Fold this frame into the token: first match, least use count
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid) begin
      if (own && !tok_i.match) begin
        tok_d.match  = 1'b1;
        tok_d.midx   = FIDX_W'(IDX);
        tok_d.muses  = uses_q;
        tok_d.mdirty = dirty_q;
      end
      if ((IDX == 0) || (uses_q < tok_i.buses)) begin
        tok_d.buses  = uses_q;
        tok_d.bidx   = FIDX_W'(IDX);
        tok_d.bown   = owner_q;
        tok_d.bpage  = page_q;
        tok_d.bdirty = dirty_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  // Load the record when the update names this frame
  always_ff @(posedge clk_i) begin
    if (upd_i.we && (upd_i.idx == FIDX_W'(IDX))) begin
      owner_q <= upd_i.owner;
      page_q  <= upd_i.page;
      uses_q  <= upd_i.uses;
      dirty_q <= upd_i.dirty;
    end
  end

endmodule

>>> rtl/lfu_page_replacement.sv
// Top level of the LFU page replacement block: controller and chain of frame cells.
//
//   channel | signals                              | word
//   in      | in_valid_i, in_ready_o, in_data_i    | lfupr_in_t  (one access)
//   out     | out_valid_o, out_ready_i, out_data_o | lfupr_out_t (one result)
//
// The result word follows the access through the start register, the cell chain
// that the token walks (one cell per cycle), the finished-token latch and the
// commit into the output register. in_ready_o rises again with the result, so
// one access is in flight at a time and a new access waits for the last result.
// A result waiting in the output register stalls only the commit step.
// Reset clears the token chain, counters and free pointer; no clearing pass.
module lfu_page_replacement #(
  parameter int unsigned FRAMES    = lfupr_pkg::FramesDef,
  parameter int unsigned PAGE_BITS = lfupr_pkg::PageBitsDef,
  parameter int unsigned PROCESSES = lfupr_pkg::ProcsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lfupr_pkg::lfupr_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output lfupr_pkg::lfupr_out_t  out_data_o
);
  import lfupr_pkg::*;

  localparam int unsigned FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned FP_W   = $clog2(FRAMES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  typedef struct packed {
    logic                 valid;
    logic                 match;
    logic [FIDX_W-1:0]    midx;
    logic [UseW-1:0]      muses;
    logic                 mdirty;
    logic [UseW-1:0]      buses;
    logic [FIDX_W-1:0]    bidx;
    logic [OwnerW-1:0]    bown;
    logic [PAGE_BITS-1:0] bpage;
    logic                 bdirty;
  } tok_t;

  typedef struct packed {
    logic                 we;
    logic [FIDX_W-1:0]    idx;
    logic [OwnerW-1:0]    owner;
    logic [PAGE_BITS-1:0] page;
    logic [UseW-1:0]      uses;
    logic                 dirty;
  } upd_t;

  logic [1:0]           state_q, state_d;
  logic                 start_q;
  logic [1:0]           proc_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [15:0]          offset_q;
  logic                 wr_q;
  logic [FP_W-1:0]      free_ptr_q;
  logic [31:0]          fault_q, swap_q;
  tok_t                 end_q;
  logic                 out_valid_q;
  lfupr_out_t           out_q;
  tok_t                 chain [FRAMES+1];
  upd_t                 upd;
  logic                 in_acc, commit;
  logic [4:0]           proc_ext;
  logic [19:0]          page_ext, evp_ext;
  logic [31:0]          frame_ext;
  logic [FIDX_W-1:0]    frame;
  logic                 free_left;
  logic                 ev, swp;
  logic [31:0]          fault_d, swap_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign page_ext   = 20'(in_data_i.virtual_page);

  // Fold the process number into range by repeated subtraction
  always_comb begin
    proc_ext = 5'(in_data_i.process_id);
    for (int i = 0; i < 3; i++) begin
      if (proc_ext >= 5'(PROCESSES)) proc_ext = proc_ext - 5'(PROCESSES);
    end
  end

  // Launch a token into the first cell
  assign chain[0] = {start_q, {($bits(tok_t)-1){1'b0}}};

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lfupr_cell #(
      .IDX(g), .FIDX_W(FIDX_W), .FP_W(FP_W), .PAGE_BITS(PAGE_BITS),
      .tok_t(tok_t), .upd_t(upd_t)
    ) u_cell (
      .clk_i, .rst_ni,
      .q_proc_i(proc_q), .q_page_i(page_q), .free_ptr_i(free_ptr_q),
      .upd_i(upd), .tok_i(chain[g]), .tok_o(chain[g+1])
    );
  end

  // Sequence: idle, scan, commit
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_SCAN;
      S_SCAN:  if (chain[FRAMES].valid) state_d = S_FIN;
      S_FIN:   if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Resolve hit, free fill or eviction from the finished token
  always_comb begin
    free_left = (free_ptr_q < FP_W'(FRAMES));
    ev        = 1'b0;
    swp       = 1'b0;
    fault_d   = fault_q;
    swap_d    = swap_q;
    upd.we    = commit;
    upd.owner = proc_q;
    upd.page  = page_q;
    if (end_q.match) begin
      frame     = end_q.midx;
      upd.uses  = (end_q.muses == UseMax) ? end_q.muses : end_q.muses + 1'b1;
      upd.dirty = end_q.mdirty | wr_q;
    end else begin
      fault_d   = (fault_q == '1) ? fault_q : fault_q + 1'b1;
      upd.uses  = UseW'(1);
      upd.dirty = wr_q;
      if (free_left) begin
        frame = free_ptr_q[FIDX_W-1:0];
      end else begin
        frame = end_q.bidx;
        ev    = 1'b1;
        swp   = end_q.bdirty;
        if (swp) swap_d = (swap_q == '1) ? swap_q : swap_q + 1'b1;
      end
    end
    upd.idx   = frame;
    frame_ext = 32'(frame);
    evp_ext   = 20'(end_q.bpage);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      free_ptr_q  <= '0;
      fault_q     <= '0;
      swap_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_acc;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (commit) begin
        out_valid_q <= 1'b1;
        fault_q     <= fault_d;
        swap_q      <= swap_d;
        if (!end_q.match && free_left) free_ptr_q <= free_ptr_q + 1'b1;
      end
    end
  end

  // Hold the query and the finished token; build the result word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      proc_q   <= proc_ext[1:0];
      page_q   <= page_ext[PAGE_BITS-1:0];
      offset_q <= in_data_i.page_offset;
      wr_q     <= in_data_i.is_write;
    end
    if (state_q == S_SCAN && chain[FRAMES].valid) end_q <= chain[FRAMES];
    if (commit) begin
      out_q.hit             <= end_q.match;
      out_q.frame_index     <= frame_ext[7:0];
      out_q.phys_offset     <= offset_q;
      out_q.evicted         <= ev;
      out_q.evicted_process <= ev ? end_q.bown : 2'd0;
      out_q.evicted_page    <= ev ? evp_ext[15:0] : 16'd0;
      out_q.swap_out        <= swp;
      out_q.fault_total     <= fault_d;
      out_q.swap_total      <= swap_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/lfupr_checker.sv
// Port-level checker for the LFU page replacement block, with its bind.
`include "lfu_page_replacement_defines.svh"

module lfupr_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input lfupr_pkg::lfupr_out_t out_data_o
);

  // A stalled result word holds
  `LFUPR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result word changed while stalled")

  // One access in flight: ready drops after an accepted word
  `LFUPR_ASSERT(a_one_busy, in_valid_i && in_ready_o |=> !in_ready_o, "second word taken during a lookup")

  // A hit never evicts
  `LFUPR_NEVER(a_hit_no_ev, out_valid_o && out_data_o.hit && out_data_o.evicted, "hit reported an eviction")

  // Without eviction the victim fields are zero
  `LFUPR_ASSERT(a_ev_fields, out_valid_o && !out_data_o.evicted |-> !out_data_o.swap_out && out_data_o.evicted_process == 2'd0 && out_data_o.evicted_page == 16'd0, "victim fields set without eviction")

endmodule

bind lfu_page_replacement lfupr_checker u_lfupr_checker (.*);
